### rtl/radial_stick_deadzone_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the radial stick deadzone block
// Concurrent checks sampled on the rising clock edge, off while in reset.
// ---------------------------------------------------------------------------
`ifndef RADIAL_STICK_DEADZONE_MACROS_SVH
`define RADIAL_STICK_DEADZONE_MACROS_SVH

// Same-cycle implication
`define RSD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define RSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/rsd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Radial stick deadzone package
// Sample widths, fixed-point constants, stage map and payload types.
// ---------------------------------------------------------------------------
package rsd_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int SB          = SAMPLE_BITS;
	localparam int DZ_W        = SB - 1;
	localparam int DZ_SQ_W     = 2 * DZ_W;
	localparam int SQ_W        = 2 * SB;
	localparam int NUMR_W      = 2 * SB - 1;
	localparam int SQRT_SIDE_W = 2 * SB + 3;
	localparam int DIVR_SIDE_W = 3 * SB + 3;

	// 1.0 and the largest output magnitude in Q1.(SB-1)
	localparam logic [SB-1:0] ONE_Q     = {1'b1, {(SB-1){1'b0}}};
	localparam logic [SB-1:0] OUT_MAX_U = {1'b0, {(SB-1){1'b1}}};
	localparam logic [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

	// Deadzone reset is 0.25 of full scale
	localparam logic [DZ_W-1:0]    DZ_RESET    = DZ_W'(1) << (SB - 3);
	localparam logic [DZ_SQ_W-1:0] DZ_SQ_RESET = DZ_SQ_W'(1) << (2 * SB - 6);

	// Stage map: square, sum, root steps, rescale prep, rescale divide,
	// component multiply, component divide, output
	localparam int SQRT_FIRST  = 2;
	localparam int PREP_STG    = SB + 2;
	localparam int DIVR_FIRST  = SB + 3;
	localparam int MULT_STG    = 2 * SB + 3;
	localparam int DIVXY_FIRST = 2 * SB + 4;
	localparam int OUT_STG     = 3 * SB + 4;
	localparam int PIPE_STAGES = 3 * SB + 5;

	typedef struct packed {
		logic signed [SB-1:0] x_in;
		logic signed [SB-1:0] y_in;
	} rsd_in_t;

	typedef struct packed {
		logic signed [SB-1:0] x_out;
		logic signed [SB-1:0] y_out;
		logic                 in_deadzone;
	} rsd_out_t;

endpackage

### rtl/rsd_sqrt.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit floor square root, one result bit per register stage,
// with a sideband word that travels alongside.
// ---------------------------------------------------------------------------
module rsd_sqrt #(
	parameter int ROOT_W = 16,
	parameter int SIDE_W = 1
) (
	input  logic                  clk,
	input  logic [ROOT_W-1:0]     en,
	input  logic [2*ROOT_W-1:0]   rad,
	input  logic [SIDE_W-1:0]     side_in,
	output logic [ROOT_W-1:0]     root,
	output logic [SIDE_W-1:0]     side_out
);

	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;

	logic [RAD_W-1:0]  rad_s   [ROOT_W];
	logic [REM_W-1:0]  rem_s   [ROOT_W];
	logic [ROOT_W-1:0] root_s  [ROOT_W];
	logic [SIDE_W-1:0] side_s  [ROOT_W];

	logic [RAD_W-1:0]  rad_cur  [ROOT_W];
	logic [REM_W-1:0]  rem_cur  [ROOT_W];
	logic [ROOT_W-1:0] root_cur [ROOT_W];
	logic [SIDE_W-1:0] side_cur [ROOT_W];
	logic [REM_W-1:0]  trial_rem [ROOT_W];
	logic [REM_W-1:0]  trial     [ROOT_W];
	logic [ROOT_W-1:0] fits;

	always_comb begin
		rad_cur[0]  = rad;
		rem_cur[0]  = '0;
		root_cur[0] = '0;
		side_cur[0] = side_in;
		for (int k = 1; k < ROOT_W; k++) begin
			rad_cur[k]  = rad_s[k-1];
			rem_cur[k]  = rem_s[k-1];
			root_cur[k] = root_s[k-1];
			side_cur[k] = side_s[k-1];
		end
	end

	// Bring down the next two radicand bits and try 4*root+1
	always_comb begin
		for (int k = 0; k < ROOT_W; k++) begin
			trial_rem[k] = {rem_cur[k][REM_W-3:0], rad_cur[k][RAD_W-1 -: 2]};
			trial[k]     = {root_cur[k], 2'b01};
			fits[k]      = trial_rem[k] >= trial[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < ROOT_W; k++) begin
			if (en[k]) begin
				rad_s[k]  <= rad_cur[k] << 2;
				rem_s[k]  <= fits[k] ? (trial_rem[k] - trial[k]) : trial_rem[k];
				root_s[k] <= {root_cur[k][ROOT_W-2:0], fits[k]};
				side_s[k] <= side_cur[k];
			end
		end
	end

	assign root     = root_s[ROOT_W-1];
	assign side_out = side_s[ROOT_W-1];

endmodule

### rtl/rsd_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage. The numerator shifted down by Q_W
// must be below the divisor, so the quotient fits in Q_W bits.
// ---------------------------------------------------------------------------
module rsd_div #(
	parameter int NUM_W  = 32,
	parameter int DEN_W  = 16,
	parameter int Q_W    = 16,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic [Q_W-1:0]    en,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic [Q_W-1:0]    quo,
	output logic [SIDE_W-1:0] side_out
);

	localparam int REM_W = DEN_W + 1;

	logic [REM_W-1:0]  rem_s  [Q_W];
	logic [Q_W-1:0]    low_s  [Q_W];
	logic [DEN_W-1:0]  den_s  [Q_W];
	logic [SIDE_W-1:0] side_s [Q_W];

	logic [REM_W-1:0]  rem_cur  [Q_W];
	logic [Q_W-1:0]    low_cur  [Q_W];
	logic [DEN_W-1:0]  den_cur  [Q_W];
	logic [SIDE_W-1:0] side_cur [Q_W];
	logic [REM_W-1:0]  trial    [Q_W];
	logic [Q_W-1:0]    fits;

	always_comb begin
		rem_cur[0]  = REM_W'(num >> Q_W);
		low_cur[0]  = num[Q_W-1:0];
		den_cur[0]  = den;
		side_cur[0] = side_in;
		for (int k = 1; k < Q_W; k++) begin
			rem_cur[k]  = rem_s[k-1];
			low_cur[k]  = low_s[k-1];
			den_cur[k]  = den_s[k-1];
			side_cur[k] = side_s[k-1];
		end
	end

	always_comb begin
		for (int k = 0; k < Q_W; k++) begin
			trial[k] = {rem_cur[k][REM_W-2:0], low_cur[k][Q_W-1]};
			fits[k]  = trial[k] >= {1'b0, den_cur[k]};
		end
	end

	// Low word shifts numerator bits out and quotient bits in
	always_ff @(posedge clk) begin
		for (int k = 0; k < Q_W; k++) begin
			if (en[k]) begin
				rem_s[k]  <= fits[k] ? (trial[k] - {1'b0, den_cur[k]}) : trial[k];
				low_s[k]  <= {low_cur[k][Q_W-2:0], fits[k]};
				den_s[k]  <= den_cur[k];
				side_s[k] <= side_cur[k];
			end
		end
	end

	assign quo      = low_s[Q_W-1];
	assign side_out = side_s[Q_W-1];

endmodule

### rtl/radial_stick_deadzone.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Radial stick deadzone
// Scaled radial deadzone for one analog stick sample in signed Q1.15.
// ---------------------------------------------------------------------------
// Channel   Handshake                      Payload
// sample    sample_valid / sample_ready    rsd_in_t  {x_in, y_in}
// result    result_valid / result_ready    rsd_out_t {x_out, y_out, in_deadzone}
// deadzone  deadzone_we                    deadzone_wdata (15 bits)
//
// One item per cycle unless stalled; items pass through the 16-step square root
// and the two 16-step divider chains, one bit per stage.
// Reset clears all stage valid bits and loads the deadzone with 0.25.
// A stage holds while it and all later stages are full and the result is not
// taken; empty stages keep filling, so input continues into any bubble.
// ---------------------------------------------------------------------------
module radial_stick_deadzone import rsd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            sample_valid,
	output logic            sample_ready,
	input  rsd_in_t         sample,
	output logic            result_valid,
	input  logic            result_ready,
	output rsd_out_t        result,
	input  logic            deadzone_we,
	input  logic [DZ_W-1:0] deadzone_wdata
);

	// Deadzone and its square
	logic [DZ_W-1:0]    dz_q;
	logic [DZ_SQ_W-1:0] dz_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q    <= DZ_RESET;
			dz_sq_q <= DZ_SQ_RESET;
		end else if (deadzone_we) begin
			dz_q    <= deadzone_wdata;
			dz_sq_q <= DZ_SQ_W'(deadzone_wdata) * DZ_SQ_W'(deadzone_wdata);
		end
	end

	// Stage valid bits and advance enables
	logic [PIPE_STAGES-1:0] vld_q;
	logic [PIPE_STAGES-1:0] vld_in;
	logic [PIPE_STAGES-1:0] adv;

	for (genvar k = 0; k < PIPE_STAGES; k++) begin : g_adv
		// advance when the result is taken or this or any later stage has a bubble
		assign adv[k] = result_ready | ~(&vld_q[PIPE_STAGES-1:k]);
	end

	assign vld_in = {vld_q[PIPE_STAGES-2:0], sample_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < PIPE_STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	assign sample_ready = adv[0];
	assign result_valid = vld_q[OUT_STG];

	// Stage 1: magnitudes and squares
	logic [SB-1:0]   ax_c, ay_c;
	logic [SB-1:0]   ax_s1, ay_s1;
	logic [SQ_W-1:0] sqx_s1, sqy_s1;
	logic            negx_s1, negy_s1;

	assign ax_c = sample.x_in[SB-1] ? SB'(~sample.x_in + 1'b1) : SB'(sample.x_in);
	assign ay_c = sample.y_in[SB-1] ? SB'(~sample.y_in + 1'b1) : SB'(sample.y_in);

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			ax_s1   <= ax_c;
			ay_s1   <= ay_c;
			sqx_s1  <= SQ_W'(ax_c) * SQ_W'(ax_c);
			sqy_s1  <= SQ_W'(ay_c) * SQ_W'(ay_c);
			negx_s1 <= sample.x_in[SB-1];
			negy_s1 <= sample.y_in[SB-1];
		end
	end

	// Stage 2: squared magnitude and deadzone test
	logic [SQ_W-1:0] sum_c;
	logic [SQ_W-1:0] sum_s2;
	logic            zone_s2, negx_s2, negy_s2;
	logic [SB-1:0]   ax_s2, ay_s2;

	assign sum_c = sqx_s1 + sqy_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			sum_s2  <= sum_c;
			zone_s2 <= sum_c <= SQ_W'(dz_sq_q);
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			negx_s2 <= negx_s1;
			negy_s2 <= negy_s1;
		end
	end

	// Square root
	logic [SB-1:0]          mag_m;
	logic [SQRT_SIDE_W-1:0] sqrt_side;
	logic                   zone_m, negx_m, negy_m;
	logic [SB-1:0]          ax_m, ay_m;

	rsd_sqrt #(
		.ROOT_W (SB),
		.SIDE_W (SQRT_SIDE_W)
	) u_sqrt (
		.clk      (clk),
		.en       (adv[SQRT_FIRST +: SB]),
		.rad      (sum_s2),
		.side_in  ({zone_s2, negx_s2, negy_s2, ax_s2, ay_s2}),
		.root     (mag_m),
		.side_out (sqrt_side)
	);

	assign {zone_m, negx_m, negy_m, ax_m, ay_m} = sqrt_side;

	// Stage 3: clamp and set up the rescale (C - d) * ONE / (ONE - d)
	logic [SB-1:0]          clamp_c, diff_c, den_c;
	logic                   above_c;
	logic [NUMR_W-1:0]      numr_s3;
	logic [SB-1:0]          denr_s3;
	logic [DIVR_SIDE_W-1:0] side_s3;

	assign clamp_c = (mag_m > ONE_Q) ? ONE_Q : mag_m;
	assign den_c   = ONE_Q - {1'b0, dz_q};
	assign above_c = clamp_c > {1'b0, dz_q};
	assign diff_c  = clamp_c - {1'b0, dz_q};

	always_ff @(posedge clk) begin
		if (adv[PREP_STG]) begin
			// round half up; zero when the magnitude is not past the deadzone
			numr_s3 <= above_c ? ({diff_c, {(SB-1){1'b0}}} + NUMR_W'(den_c >> 1))
			                   : '0;
			denr_s3 <= den_c;
			side_s3 <= {zone_m, negx_m, negy_m, ax_m, ay_m, mag_m};
		end
	end

	// Rescale divider
	logic [SB-1:0]          rscale;
	logic [DIVR_SIDE_W-1:0] divr_side;
	logic                   zone_r, negx_r, negy_r;
	logic [SB-1:0]          ax_r, ay_r, mag_r;

	rsd_div #(
		.NUM_W  (NUMR_W),
		.DEN_W  (SB),
		.Q_W    (SB),
		.SIDE_W (DIVR_SIDE_W)
	) u_div_r (
		.clk      (clk),
		.en       (adv[DIVR_FIRST +: SB]),
		.num      (numr_s3),
		.den      (denr_s3),
		.side_in  (side_s3),
		.quo      (rscale),
		.side_out (divr_side)
	);

	assign {zone_r, negx_r, negy_r, ax_r, ay_r, mag_r} = divr_side;

	// Stage 4: component numerators |v| * R + M / 2
	logic [SQ_W-1:0] numx_s4, numy_s4;
	logic [SB-1:0]   mag_s4;
	logic            zone_s4, negx_s4, negy_s4;

	always_ff @(posedge clk) begin
		if (adv[MULT_STG]) begin
			numx_s4 <= SQ_W'(ax_r) * SQ_W'(rscale) + SQ_W'(mag_r >> 1);
			numy_s4 <= SQ_W'(ay_r) * SQ_W'(rscale) + SQ_W'(mag_r >> 1);
			mag_s4  <= mag_r;
			zone_s4 <= zone_r;
			negx_s4 <= negx_r;
			negy_s4 <= negy_r;
		end
	end

	// Component dividers
	logic [SB-1:0] qx, qy;
	logic          zone_d, negx_d, negy_d;

	rsd_div #(
		.NUM_W  (SQ_W),
		.DEN_W  (SB),
		.Q_W    (SB),
		.SIDE_W (2)
	) u_div_x (
		.clk      (clk),
		.en       (adv[DIVXY_FIRST +: SB]),
		.num      (numx_s4),
		.den      (mag_s4),
		.side_in  ({zone_s4, negx_s4}),
		.quo      (qx),
		.side_out ({zone_d, negx_d})
	);

	rsd_div #(
		.NUM_W  (SQ_W),
		.DEN_W  (SB),
		.Q_W    (SB),
		.SIDE_W (1)
	) u_div_y (
		.clk      (clk),
		.en       (adv[DIVXY_FIRST +: SB]),
		.num      (numy_s4),
		.den      (mag_s4),
		.side_in  (negy_s4),
		.quo      (qy),
		.side_out (negy_d)
	);

	// Stage 5: saturate, restore sign, force zero inside the deadzone
	logic [SB-1:0] satx_c, saty_c, valx_c, valy_c;
	rsd_out_t      out_c;
	rsd_out_t      out_s5;

	assign satx_c = qx[SB-1] ? OUT_MAX_U : qx;
	assign saty_c = qy[SB-1] ? OUT_MAX_U : qy;
	assign valx_c = negx_d ? (~satx_c + 1'b1) : satx_c;
	assign valy_c = negy_d ? (~saty_c + 1'b1) : saty_c;

	always_comb begin
		out_c.x_out       = zone_d ? '0 : valx_c;
		out_c.y_out       = zone_d ? '0 : valy_c;
		out_c.in_deadzone = zone_d;
	end

	always_ff @(posedge clk) begin
		if (adv[OUT_STG]) begin
			out_s5 <= out_c;
		end
	end

	assign result = out_s5;

endmodule

### rtl/rsd_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Radial stick deadzone port checker
// Watches the top-level ports over time; attached by bind.
// ---------------------------------------------------------------------------
`include "radial_stick_deadzone_macros.svh"

module rsd_props import rsd_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            sample_ready,
	input logic            result_valid,
	input logic            result_ready,
	input rsd_out_t        result
);

	`RSD_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result), "result item changed while stalled")
	`RSD_ASSERT_SAME(a_zone_zero, clk, arst_n, result_valid && result.in_deadzone, result.x_out == '0 && result.y_out == '0, "deadzone item with nonzero output")
	`RSD_ASSERT_SAME(a_sat_range, clk, arst_n, result_valid, result.x_out != SAMPLE_MIN && result.y_out != SAMPLE_MIN, "output outside symmetric range")
	`RSD_ASSERT_SAME(a_ready_flow, clk, arst_n, result_ready, sample_ready, "input blocked while output drains")

endmodule

bind radial_stick_deadzone rsd_props u_rsd_props (.*);
